// ----- sv/ppp_pkg.sv -----
`default_nettype none
package ppp_pkg;

    localparam int MAX_POINTS_DEF = 1024;
    localparam int COORD_W = 32;
    localparam int ARC_W = 32;
    localparam int WID_W = 24;
    localparam int FRAC_W = 17;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W = 2;
    localparam int MUL_W = 34;
    localparam int PROD_W = 68;
    localparam int DIV_STEPS = 16;
    localparam int SQRT_STEPS = 34;
    localparam int CNT_W = 6;

    localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSED_TRACK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHORD_LENGTH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd3;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_DELTA,
        ST_LEN_X,
        ST_LEN_Y,
        ST_DOT_X,
        ST_DOT_Y,
        ST_DOT_SUM,
        ST_DIV,
        ST_FIT_X,
        ST_FIT_Y,
        ST_ERR_X,
        ST_ERR_Y,
        ST_ERR_SUM,
        ST_ARC,
        ST_LEFT,
        ST_RIGHT,
        ST_SIDE_A,
        ST_SIDE_B,
        ST_SIDE_SUM,
        ST_SQRT,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

// ----- sv/polyline_point_projection.sv -----
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_req_type, i_point_index, i_x_coord, i_y_coord,
//                                         i_arc_length, i_width_left, i_width_right
// output    out        o_valid / i_stall  o_segment_index, o_segment_fraction, o_arc_position,
//                                         o_lateral_offset, o_limit_margin, o_inside_limits
// config    in         i_cfg_we           i_cfg_index, i_cfg_data
//
// A load item writes the point memories when it is accepted. A query walks every segment through the one shared
// multiplier, and through the divider as well when its fraction needs it. A final pass over the
// winning segment and the 34-step square root follow; a result still held at the output keeps
// the block in its last state.
// Reset is synchronous and active low; the point memories are not cleared.
// While a query runs o_stall is high; a finished result waits in the output register.
`default_nettype none
module polyline_point_projection #(
    parameter int MAX_POINTS = ppp_pkg::MAX_POINTS_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_valid,
    output logic                                        o_stall,
    input  wire logic                                   i_req_type,
    input  wire logic [$clog2(MAX_POINTS)-1:0]          i_point_index,
    input  wire logic signed [ppp_pkg::COORD_W-1:0]     i_x_coord,
    input  wire logic signed [ppp_pkg::COORD_W-1:0]     i_y_coord,
    input  wire logic [ppp_pkg::ARC_W-1:0]              i_arc_length,
    input  wire logic [ppp_pkg::WID_W-1:0]              i_width_left,
    input  wire logic [ppp_pkg::WID_W-1:0]              i_width_right,
    output logic                                        o_valid,
    input  wire logic                                   i_stall,
    output logic [$clog2(MAX_POINTS)-1:0]               o_segment_index,
    output logic [ppp_pkg::FRAC_W-1:0]                  o_segment_fraction,
    output logic [ppp_pkg::ARC_W-1:0]                   o_arc_position,
    output logic signed [ppp_pkg::COORD_W-1:0]          o_lateral_offset,
    output logic signed [ppp_pkg::COORD_W-1:0]          o_limit_margin,
    output logic                                        o_inside_limits,
    input  wire logic                                   i_cfg_we,
    input  wire logic [ppp_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  wire logic [ppp_pkg::CFG_DATA_W-1:0]         i_cfg_data
);
    import ppp_pkg::*;

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = IW + 1;

    t_state r_state, n_state;

    logic [CW-1:0]           r_point_count;
    logic                    r_closed;
    logic [ARC_W-1:0]        r_chord;
    logic signed [31:0]      r_tol;

    logic [COORD_W-1:0]      r_mem_x [MAX_POINTS];
    logic [COORD_W-1:0]      r_mem_y [MAX_POINTS];
    logic [ARC_W-1:0]        r_mem_arc [MAX_POINTS];
    logic [WID_W-1:0]        r_mem_l [MAX_POINTS];
    logic [WID_W-1:0]        r_mem_r [MAX_POINTS];
    logic [COORD_W-1:0]      r_rd_x, r_rd_y;
    logic [ARC_W-1:0]        r_rd_arc;
    logic [WID_W-1:0]        r_rd_l, r_rd_r;

    logic signed [31:0]      r_qx, r_qy, r_ax, r_ay;
    logic [ARC_W-1:0]        r_arc_a, r_arc_b;
    logic [WID_W-1:0]        r_la, r_lb, r_ra, r_rb;
    logic signed [32:0]      r_dx, r_dy, r_ex, r_ey, r_errx, r_erry;
    logic signed [PROD_W-1:0] r_acc;
    logic [PROD_W-1:0]       r_len2, r_rem, r_best_d, r_sq_n;
    logic [FRAC_W-1:0]       r_t, r_best_t;
    logic [CNT_W-1:0]        r_cnt;
    logic [IW-1:0]           r_seg, r_best_seg;
    logic                    r_final;
    logic [ARC_W-1:0]        r_arc_out;
    logic [WID_W-1:0]        r_wl, r_wr;
    logic                    r_side_neg;
    logic [35:0]             r_sq_rem;
    logic [33:0]             r_root;
    logic                    r_o_valid;

    logic [CW-1:0]           w_n, w_segs;
    logic                    w_wrap, w_last, w_better, w_in_acc, w_load;
    logic [IW-1:0]           w_ib, w_raddr;
    logic signed [MUL_W-1:0] w_ma, w_mb;
    logic signed [PROD_W-1:0] w_p, w_sum, w_diff;
    logic signed [35:0]      w_round, w_errx, w_erry, w_arc_sum;
    logic [PROD_W-1:0]       w_rem2;
    logic                    w_div_ge;
    logic [35:0]             w_sq_cat, w_sq_trial;
    logic                    w_sq_ge;
    logic signed [33:0]      w_span;
    logic signed [24:0]      w_ldiff, w_rdiff;
    logic signed [25:0]      w_wl, w_wr;
    logic                    w_neg, w_out_load;
    logic signed [36:0]      w_mag, w_lat, w_margin;
    logic [WID_W-1:0]        w_edge;

    // Round(p / 65536) with ties away from zero, for a fraction times a delta.
    function automatic logic signed [35:0] f_round(input logic signed [PROD_W-1:0] p);
        logic [50:0]        mag;
        logic [34:0]        q;
        logic signed [35:0] r;
        mag = p[PROD_W-1] ? 51'(-p) : p[50:0];
        q = 35'((mag + 51'd32768) >> 16);
        r = p[PROD_W-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
        return r;
    endfunction

    function automatic logic [31:0] f_sat32(input logic signed [36:0] v);
        logic [31:0] r;
        if (v > $signed(37'h07FFFFFFF)) begin
            r = 32'h7FFFFFFF;
        end else if (v < $signed(37'h1F80000000)) begin
            r = 32'h80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    ppp_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_p)
    );

    // Point count clamped to 2..MAX_POINTS; a closed track adds the wrap segment.
    always_comb begin
        if (r_point_count < CW'(2)) begin
            w_n = CW'(2);
        end else if (r_point_count > CW'(MAX_POINTS)) begin
            w_n = CW'(MAX_POINTS);
        end else begin
            w_n = r_point_count;
        end
        w_segs = r_closed ? w_n : w_n - CW'(1);
    end

    assign o_stall  = (r_state != ST_IDLE);
    assign o_valid  = r_o_valid;
    assign w_in_acc = i_valid && !o_stall;
    assign w_load   = w_in_acc && (i_req_type == REQ_LOAD) &&
                      ({1'b0, i_point_index} < CW'(MAX_POINTS));

    assign w_wrap = ({1'b0, r_seg} + CW'(1)) == w_n;
    assign w_last = ({1'b0, r_seg} + CW'(1)) == w_segs;
    assign w_ib   = w_wrap ? '0 : r_seg + IW'(1);

    assign w_sum    = r_acc + w_p;
    assign w_diff   = r_acc - w_p;
    assign w_round  = f_round(w_p);
    assign w_errx   = $signed({{3{r_ex[32]}}, r_ex}) - w_round;
    assign w_erry   = $signed({{3{r_ey[32]}}, r_ey}) - w_round;
    assign w_better = (r_seg == '0) || (w_sum < r_best_d);

    assign w_rem2   = {r_rem[PROD_W-2:0], 1'b0};
    assign w_div_ge = w_rem2 >= r_len2;

    assign w_sq_cat   = {r_sq_rem[33:0], r_sq_n[PROD_W-1:PROD_W-2]};
    assign w_sq_trial = {r_root, 2'b01};
    assign w_sq_ge    = w_sq_cat >= w_sq_trial;

    assign w_span  = w_wrap ? $signed({2'b00, r_chord})
                            : $signed({2'b00, r_arc_b}) - $signed({2'b00, r_arc_a});
    assign w_ldiff = $signed({1'b0, r_lb}) - $signed({1'b0, r_la});
    assign w_rdiff = $signed({1'b0, r_rb}) - $signed({1'b0, r_ra});
    assign w_arc_sum = $signed({4'b0000, r_arc_a}) + w_round;
    assign w_wl = $signed({2'b00, r_la}) + w_round[25:0];
    assign w_wr = $signed({2'b00, r_ra}) + w_round[25:0];

    // Zero offset counts as left.
    assign w_mag    = $signed({3'b000, r_root});
    assign w_neg    = r_side_neg && (r_root != '0);
    assign w_lat    = w_neg ? -w_mag : w_mag;
    assign w_edge   = w_neg ? r_wr : r_wl;
    assign w_margin = $signed({13'b0, w_edge}) + $signed({{5{r_tol[31]}}, r_tol}) - w_mag;
    assign w_out_load = (r_state == ST_DONE) && (!r_o_valid || !i_stall);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (w_in_acc && i_req_type == REQ_QUERY) n_state = ST_RD_A;
            ST_RD_A:    n_state = ST_RD_B;
            ST_RD_B:    n_state = ST_DELTA;
            ST_DELTA:   n_state = r_final ? ST_ARC : ST_LEN_X;
            ST_LEN_X:   n_state = ST_LEN_Y;
            ST_LEN_Y:   n_state = ST_DOT_X;
            ST_DOT_X:   n_state = ST_DOT_Y;
            ST_DOT_Y:   n_state = ST_DOT_SUM;
            ST_DOT_SUM: begin
                if (r_len2 == '0 || w_sum[PROD_W-1] || w_sum == '0 ||
                    $unsigned(w_sum) >= r_len2) begin
                    n_state = ST_FIT_X;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV:     if (r_cnt == CNT_W'(DIV_STEPS - 1)) n_state = ST_FIT_X;
            ST_FIT_X:   n_state = ST_FIT_Y;
            ST_FIT_Y:   n_state = ST_ERR_X;
            ST_ERR_X:   n_state = ST_ERR_Y;
            ST_ERR_Y:   n_state = ST_ERR_SUM;
            ST_ERR_SUM: n_state = ST_RD_A;
            ST_ARC:     n_state = ST_LEFT;
            ST_LEFT:    n_state = ST_RIGHT;
            ST_RIGHT:   n_state = ST_SIDE_A;
            ST_SIDE_A:  n_state = ST_SIDE_B;
            ST_SIDE_B:  n_state = ST_SIDE_SUM;
            ST_SIDE_SUM: n_state = ST_SQRT;
            ST_SQRT:    if (r_cnt == CNT_W'(SQRT_STEPS - 1)) n_state = ST_DONE;
            ST_DONE:    if (w_out_load) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // Memory address and multiplier operands.
    always_comb begin
        w_raddr = r_seg;
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            ST_RD_B:   w_raddr = w_ib;
            ST_LEN_X:  begin w_ma = {r_dx[32], r_dx}; w_mb = {r_dx[32], r_dx}; end
            ST_LEN_Y:  begin w_ma = {r_dy[32], r_dy}; w_mb = {r_dy[32], r_dy}; end
            ST_DOT_X:  begin w_ma = {r_ex[32], r_ex}; w_mb = {r_dx[32], r_dx}; end
            ST_DOT_Y:  begin w_ma = {r_ey[32], r_ey}; w_mb = {r_dy[32], r_dy}; end
            ST_FIT_X:  begin w_ma = {17'b0, r_t}; w_mb = {r_dx[32], r_dx}; end
            ST_FIT_Y:  begin w_ma = {17'b0, r_t}; w_mb = {r_dy[32], r_dy}; end
            ST_ERR_X:  begin w_ma = {r_errx[32], r_errx}; w_mb = {r_errx[32], r_errx}; end
            ST_ERR_Y:  begin w_ma = {r_erry[32], r_erry}; w_mb = {r_erry[32], r_erry}; end
            ST_ARC:    begin w_ma = {17'b0, r_t}; w_mb = w_span; end
            ST_LEFT:   begin w_ma = {17'b0, r_t}; w_mb = {{9{w_ldiff[24]}}, w_ldiff}; end
            ST_RIGHT:  begin w_ma = {17'b0, r_t}; w_mb = {{9{w_rdiff[24]}}, w_rdiff}; end
            ST_SIDE_A: begin w_ma = {r_dx[32], r_dx}; w_mb = {r_ey[32], r_ey}; end
            ST_SIDE_B: begin w_ma = {r_dy[32], r_dy}; w_mb = {r_ex[32], r_ex}; end
            default:   begin w_raddr = r_seg; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_mem_x[i_point_index]   <= i_x_coord;
            r_mem_y[i_point_index]   <= i_y_coord;
            r_mem_arc[i_point_index] <= i_arc_length;
            r_mem_l[i_point_index]   <= i_width_left;
            r_mem_r[i_point_index]   <= i_width_right;
        end
        r_rd_x   <= r_mem_x[w_raddr];
        r_rd_y   <= r_mem_y[w_raddr];
        r_rd_arc <= r_mem_arc[w_raddr];
        r_rd_l   <= r_mem_l[w_raddr];
        r_rd_r   <= r_mem_r[w_raddr];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_o_valid     <= 1'b0;
            r_point_count <= CW'(2);
            r_closed      <= 1'b0;
            r_chord       <= '0;
            r_tol         <= '0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_POINT_COUNT:  r_point_count <= i_cfg_data[CW-1:0];
                    CFG_CLOSED_TRACK: r_closed <= i_cfg_data[0];
                    CFG_CHORD_LENGTH: r_chord <= i_cfg_data[ARC_W-1:0];
                    CFG_TOLERANCE:    r_tol <= i_cfg_data[31:0];
                    default:          r_closed <= r_closed;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_qx    <= i_x_coord;
                r_qy    <= i_y_coord;
                r_seg   <= '0;
                r_final <= 1'b0;
            end
            ST_RD_B: begin
                r_ax    <= r_rd_x;
                r_ay    <= r_rd_y;
                r_arc_a <= r_rd_arc;
                r_la    <= r_rd_l;
                r_ra    <= r_rd_r;
            end
            ST_DELTA: begin
                r_dx    <= $signed({r_rd_x[31], r_rd_x}) - $signed({r_ax[31], r_ax});
                r_dy    <= $signed({r_rd_y[31], r_rd_y}) - $signed({r_ay[31], r_ay});
                r_ex    <= $signed({r_qx[31], r_qx}) - $signed({r_ax[31], r_ax});
                r_ey    <= $signed({r_qy[31], r_qy}) - $signed({r_ay[31], r_ay});
                r_arc_b <= r_rd_arc;
                r_lb    <= r_rd_l;
                r_rb    <= r_rd_r;
            end
            ST_LEN_Y: r_acc <= w_p;
            ST_DOT_X: r_len2 <= w_sum;
            ST_DOT_Y: r_acc <= w_p;
            ST_DOT_SUM: begin
                r_rem <= w_sum;
                r_cnt <= '0;
                if (r_len2 == '0 || w_sum[PROD_W-1] || w_sum == '0) begin
                    r_t <= '0;
                end else if ($unsigned(w_sum) >= r_len2) begin
                    r_t <= FRAC_ONE;
                end else begin
                    r_t <= '0;
                end
            end
            ST_DIV: begin
                r_rem <= w_div_ge ? w_rem2 - r_len2 : w_rem2;
                r_t   <= {r_t[FRAC_W-2:0], w_div_ge};
                r_cnt <= r_cnt + CNT_W'(1);
            end
            ST_FIT_Y: r_errx <= w_errx[32:0];
            ST_ERR_X: r_erry <= w_erry[32:0];
            ST_ERR_Y: r_acc <= w_p;
            ST_ERR_SUM: begin
                if (w_better) begin
                    r_best_d   <= w_sum;
                    r_best_seg <= r_seg;
                    r_best_t   <= r_t;
                end
                if (w_last) begin
                    // Rewind to the winning segment for the final pass.
                    r_final <= 1'b1;
                    r_seg   <= w_better ? r_seg : r_best_seg;
                    r_t     <= w_better ? r_t : r_best_t;
                    if (w_better) begin
                        r_sq_n <= w_sum;
                    end else begin
                        r_sq_n <= r_best_d;
                    end
                end else begin
                    r_seg <= r_seg + IW'(1);
                end
            end
            ST_LEFT: begin
                if (w_arc_sum[35]) begin
                    r_arc_out <= '0;
                end else if (w_arc_sum[35:32] != 4'b0000) begin
                    r_arc_out <= '1;
                end else begin
                    r_arc_out <= w_arc_sum[31:0];
                end
            end
            ST_RIGHT:  r_wl <= w_wl[WID_W-1:0];
            ST_SIDE_A: r_wr <= w_wr[WID_W-1:0];
            ST_SIDE_B: r_acc <= w_p;
            ST_SIDE_SUM: begin
                r_side_neg <= w_diff[PROD_W-1];
                r_sq_rem   <= '0;
                r_root     <= '0;
                r_cnt      <= '0;
            end
            ST_SQRT: begin
                r_sq_n   <= {r_sq_n[PROD_W-3:0], 2'b00};
                r_sq_rem <= w_sq_ge ? w_sq_cat - w_sq_trial : w_sq_cat;
                r_root   <= {r_root[32:0], w_sq_ge};
                r_cnt    <= r_cnt + CNT_W'(1);
            end
            default: r_cnt <= r_cnt;
        endcase
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            o_segment_index    <= r_seg;
            o_segment_fraction <= r_t;
            o_arc_position     <= r_arc_out;
            o_lateral_offset   <= f_sat32(w_lat);
            o_limit_margin     <= f_sat32(w_margin);
            o_inside_limits    <= !w_margin[36];
        end
    end

`ifndef SYNTHESIS
    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (o_segment_fraction <= FRAC_ONE))
        else $error("fraction beyond one");

    a_div_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_cnt < CNT_W'(DIV_STEPS)))
        else $error("divider ran past its steps");

    a_sqrt_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQRT) |-> (r_sq_rem <= {1'b0, r_root, 1'b0}))
        else $error("square root remainder out of bound");
`endif

endmodule
`default_nettype wire

// ----- sv/ppp_mul.sv -----
`default_nettype none
module ppp_mul (
    input  wire logic                              i_clk,
    input  wire logic signed [ppp_pkg::MUL_W-1:0]  i_a,
    input  wire logic signed [ppp_pkg::MUL_W-1:0]  i_b,
    output logic signed [ppp_pkg::PROD_W-1:0]      o_p
);
    import ppp_pkg::*;

    always_ff @(posedge i_clk) begin
        o_p <= i_a * i_b;
    end

endmodule
`default_nettype wire

// ----- verif/polyline_point_projection_test.sv -----
`timescale 1ns / 100ps
`default_nettype none
module polyline_point_projection_test;
    import ppp_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        bit                  is_cfg;
        logic [CFG_IDX_W-1:0] cfg_idx;
        logic [31:0]         cfg_data;
        logic                req;
        logic [9:0]          idx;
        logic signed [31:0]  x;
        logic signed [31:0]  y;
        logic [31:0]         arc;
        logic [23:0]         wl;
        logic [23:0]         wr;
    } t_request;

    typedef struct {
        logic [9:0]         seg;
        logic [16:0]        frac;
        logic [31:0]        arc;
        logic signed [31:0] lat;
        logic signed [31:0] margin;
        logic               in_limits;
    } t_projection;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic i_req_type = REQ_LOAD;
    logic [9:0] i_point_index = '0;
    logic signed [31:0] i_x_coord = '0;
    logic signed [31:0] i_y_coord = '0;
    logic [31:0] i_arc_length = '0;
    logic [23:0] i_width_left = '0;
    logic [23:0] i_width_right = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [9:0] o_segment_index;
    logic [16:0] o_segment_fraction;
    logic [31:0] o_arc_position;
    logic signed [31:0] o_lateral_offset;
    logic signed [31:0] o_limit_margin;
    logic o_inside_limits;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    polyline_point_projection uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_req_type(i_req_type), .i_point_index(i_point_index),
        .i_x_coord(i_x_coord), .i_y_coord(i_y_coord), .i_arc_length(i_arc_length),
        .i_width_left(i_width_left), .i_width_right(i_width_right),
        .o_valid(o_valid), .i_stall(i_stall), .o_segment_index(o_segment_index),
        .o_segment_fraction(o_segment_fraction), .o_arc_position(o_arc_position),
        .o_lateral_offset(o_lateral_offset), .o_limit_margin(o_limit_margin),
        .o_inside_limits(o_inside_limits), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    t_request    pending[$];
    t_projection projections_due[$];
    bit          failed = 1'b0;

    // Shadow copy of the centerline and registers.
    logic signed [31:0] pt_x[1024];
    logic signed [31:0] pt_y[1024];
    logic [31:0]        pt_arc[1024];
    logic [23:0]        pt_left[1024];
    logic [23:0]        pt_right[1024];
    logic [10:0]        cfg_count = 11'd2;
    logic               cfg_closed = 1'b0;
    logic [31:0]        cfg_chord = '0;
    logic signed [31:0] cfg_tol = '0;

    // round(t * v / 65536), ties away from zero
    function automatic logic signed [127:0] frac_scale(input logic [16:0] t,
                                                       input logic signed [127:0] v);
        logic [127:0] m;
        logic [127:0] p;
        m = (v < 0) ? -v : v;
        p = (m * t + 128'd32768) >> 16;
        return (v < 0) ? -$signed(p) : $signed(p);
    endfunction

    function automatic logic [127:0] segment_dist2(input int ia, input int ib,
                                                   input logic signed [127:0] qx,
                                                   input logic signed [127:0] qy,
                                                   output logic [16:0] t);
        logic signed [127:0] ax, ay, dx, dy, len2, dot, ex, ey;
        ax = pt_x[ia];
        ay = pt_y[ia];
        dx = pt_x[ib] - ax;
        dy = pt_y[ib] - ay;
        len2 = dx * dx + dy * dy;
        t = '0;
        if (len2 != 0) begin
            dot = (qx - ax) * dx + (qy - ay) * dy;
            if (dot <= 0) t = '0;
            else if (dot >= len2) t = FRAC_ONE;
            else t = 17'((dot <<< 16) / len2);
        end
        ex = qx - (ax + frac_scale(t, dx));
        ey = qy - (ay + frac_scale(t, dy));
        return ex * ex + ey * ey;
    endfunction

    function automatic t_projection project_query(input logic signed [31:0] x,
                                                  input logic signed [31:0] y);
        t_projection r;
        int n, segs, best, ib;
        logic [16:0] t, best_t;
        logic [127:0] d, best_d, c, root;
        logic signed [127:0] qx, qy, span, arc, ax, ay, side, wl, wr, edge_w, margin, lat;
        bit neg;
        n = cfg_count;
        if (n < 2) n = 2;
        if (n > 1024) n = 1024;
        segs = cfg_closed ? n : n - 1;
        qx = x;
        qy = y;
        best = 0;
        best_t = '0;
        best_d = '0;
        for (int i = 0; i < segs; i++) begin
            d = segment_dist2(i, (i + 1 == n) ? 0 : i + 1, qx, qy, t);
            if (i == 0 || d < best_d) begin
                best_d = d;
                best = i;
                best_t = t;
            end
        end
        ib = (best + 1 == n) ? 0 : best + 1;
        if (best + 1 == n) span = cfg_chord;
        else span = $signed({96'd0, pt_arc[ib]}) - $signed({96'd0, pt_arc[best]});
        arc = $signed({96'd0, pt_arc[best]}) + frac_scale(best_t, span);
        if (arc < 0) arc = 0;
        if (arc > 128'sh0FFFFFFFF) arc = 128'sh0FFFFFFFF;
        ax = pt_x[best];
        ay = pt_y[best];
        side = (pt_x[ib] - ax) * (qy - ay) - (pt_y[ib] - ay) * (qx - ax);
        root = '0;
        for (int k = 34; k >= 0; k--) begin
            c = root | (128'd1 << k);
            if (c * c <= best_d) root = c;
        end
        neg = (side < 0) && (root != 0);
        lat = neg ? -$signed(root) : $signed(root);
        wl = $signed({104'd0, pt_left[best]}) + frac_scale(best_t,
             $signed({104'd0, pt_left[ib]}) - $signed({104'd0, pt_left[best]}));
        wr = $signed({104'd0, pt_right[best]}) + frac_scale(best_t,
             $signed({104'd0, pt_right[ib]}) - $signed({104'd0, pt_right[best]}));
        edge_w = neg ? wr : wl;
        margin = edge_w + cfg_tol - $signed(root);
        r.seg = 10'(best);
        r.frac = best_t;
        r.arc = arc[31:0];
        r.lat = (lat > 2147483647) ? 32'sh7FFFFFFF :
                (lat < -128'sd2147483648) ? 32'sh80000000 : lat[31:0];
        r.margin = (margin > 2147483647) ? 32'sh7FFFFFFF :
                   (margin < -128'sd2147483648) ? 32'sh80000000 : margin[31:0];
        r.in_limits = (margin >= 0);
        return r;
    endfunction

    // Driver: items, configuration writes and source-side gaps.
    t_request cur;
    int gap = 0;
    int settle = 0;
    int burst = 0;

    always @(posedge i_clk) begin
        logic nv, nwe;
        t_request nx;
        nv = i_valid;
        nwe = 1'b0;
        if (!i_rst_n) begin
            nv = 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                if (cur.req == REQ_LOAD) begin
                    pt_x[cur.idx] = cur.x;
                    pt_y[cur.idx] = cur.y;
                    pt_arc[cur.idx] = cur.arc;
                    pt_left[cur.idx] = cur.wl;
                    pt_right[cur.idx] = cur.wr;
                end else begin
                    projections_due.push_back(project_query(cur.x, cur.y));
                end
                nv = 1'b0;
                if (burst > 0) begin
                    burst--;
                    gap = 0;
                end else begin
                    gap = $urandom_range(0, 9);
                    if ($urandom_range(0, 15) == 0) burst = $urandom_range(5, 25);
                end
            end
            if (i_valid || projections_due.size() != 0) settle = 0;
            else if (settle < SETTLE_CYCLES) settle++;
            if (!nv) begin
                if (gap > 0) begin
                    gap--;
                end else if (pending.size() != 0) begin
                    if (pending[0].is_cfg) begin
                        // Registers change only once the block has gone quiet.
                        if (settle >= SETTLE_CYCLES) begin
                            nx = pending.pop_front();
                            nwe = 1'b1;
                            i_cfg_index <= nx.cfg_idx;
                            i_cfg_data <= nx.cfg_data;
                            case (nx.cfg_idx)
                                CFG_POINT_COUNT:  cfg_count = nx.cfg_data[10:0];
                                CFG_CLOSED_TRACK: cfg_closed = nx.cfg_data[0];
                                CFG_CHORD_LENGTH: cfg_chord = nx.cfg_data;
                                default:          cfg_tol = nx.cfg_data;
                            endcase
                        end
                    end else begin
                        cur = pending.pop_front();
                        nv = 1'b1;
                        i_req_type <= cur.req;
                        i_point_index <= cur.idx;
                        i_x_coord <= cur.x;
                        i_y_coord <= cur.y;
                        i_arc_length <= cur.arc;
                        i_width_left <= cur.wl;
                        i_width_right <= cur.wr;
                    end
                end
            end
        end
        i_valid <= nv;
        i_cfg_we <= nwe;
    end

    // Monitor: checks results and stalls the output at random.
    int hold = 0;

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
            failed = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        t_projection e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (projections_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, got segment %0d", $time,
                         o_segment_index);
                failed = 1'b1;
            end else begin
                e = projections_due.pop_front();
                check_field("segment_index", e.seg, o_segment_index);
                check_field("segment_fraction", e.frac, o_segment_fraction);
                check_field("arc_position", e.arc, o_arc_position);
                check_field("lateral_offset", e.lat, o_lateral_offset);
                check_field("limit_margin", e.margin, o_limit_margin);
                check_field("inside_limits", e.in_limits, o_inside_limits);
            end
            hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
        end else if (hold > 0) begin
            hold--;
        end
        i_stall <= (hold > 0);
    end

    int quiet = 0;
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        t_request r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.cfg_idx = idx;
        r.cfg_data = data;
        pending.push_back(r);
    endtask

    task automatic add_load(input int idx, input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] arc, input logic [23:0] wl,
                            input logic [23:0] wr);
        t_request r;
        r = '{default: '0};
        r.req = REQ_LOAD;
        r.idx = 10'(idx);
        r.x = x;
        r.y = y;
        r.arc = arc;
        r.wl = wl;
        r.wr = wr;
        pending.push_back(r);
    endtask

    task automatic add_query(input logic [31:0] x, input logic [31:0] y);
        t_request r;
        r = '{default: '0};
        r.req = REQ_QUERY;
        r.x = x;
        r.y = y;
        // Fields unused by a query still get random values.
        r.idx = 10'($urandom);
        r.arc = $urandom;
        r.wl = 24'($urandom);
        r.wr = 24'($urandom);
        pending.push_back(r);
    endtask

    function automatic logic [31:0] near_coord();
        if ($urandom_range(0, 7) == 0) return $urandom;
        return $urandom_range(0, 32'h003FFFFF) - 32'h00200000;
    endfunction

    task automatic load_track(input int n);
        logic [31:0] arc;
        arc = $urandom_range(0, 32'h00100000);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 7) == 0) arc = $urandom;
            else arc = arc + $urandom_range(0, 32'h00100000);
            add_load(i, near_coord(), near_coord(), arc,
                     ($urandom_range(0, 5) == 0) ? 24'($urandom) : 24'($urandom_range(0, 32'h60000)),
                     ($urandom_range(0, 5) == 0) ? 24'($urandom) : 24'($urandom_range(0, 32'h60000)));
        end
    endtask

    initial begin
        int n;
        // Directed: one straight segment, default registers.
        add_load(0, 32'h0, 32'h0, 32'h0, 24'h010000, 24'h020000);
        add_load(1, 32'h000A0000, 32'h0, 32'h000A0000, 24'h030000, 24'h008000);
        add_query(-32'sh10000, 32'h8000);      // before the start point
        add_query(32'h50000, 32'h18000);       // left of the segment
        add_query(32'h50000, -32'sh18000);     // right of the segment
        add_query(32'h30000, 32'h0);           // on the centerline, offset zero
        add_query(32'hF0000, 32'h0);           // past the end point
        add_cfg(CFG_TOLERANCE, 32'h7FFFFFFF);
        add_query(32'h50000, 32'h7FFFFFFF);
        add_cfg(CFG_TOLERANCE, 32'h80000000);
        add_query(32'h50000, -32'sh18000);
        // A segment of zero length.
        add_load(1, 32'h0, 32'h0, 32'h00050000, 24'h0, 24'hFFFFFF);
        add_query(32'h12345, -32'sh54321);
        // Coordinate, arc and width extremes.
        add_load(0, 32'h80000000, 32'h80000000, 32'hFFFFFFFF, 24'hFFFFFF, 24'h0);
        add_load(1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0, 24'h0, 24'hFFFFFF);
        add_query(32'h80000000, 32'h7FFFFFFF);
        add_query(32'h7FFFFFFF, 32'h80000000);
        // Closed track with a count below the minimum.
        add_cfg(CFG_TOLERANCE, 32'h0);
        add_cfg(CFG_POINT_COUNT, 32'h0);
        add_cfg(CFG_CLOSED_TRACK, 32'h1);
        add_cfg(CFG_CHORD_LENGTH, 32'hFFFFFFFF);
        add_query(32'h0, 32'h0);
        add_cfg(CFG_POINT_COUNT, 32'h1);
        add_query(32'h7FFFFFFF, 32'h7FFFFFFF);

        // Random tracks, mostly short.
        for (int phase = 0; phase < 8; phase++) begin
            n = $urandom_range(2, 8);
            add_cfg(CFG_POINT_COUNT, n);
            add_cfg(CFG_CLOSED_TRACK, $urandom_range(0, 1));
            add_cfg(CFG_CHORD_LENGTH, ($urandom_range(0, 3) == 0) ? $urandom :
                    $urandom_range(0, 32'h00400000));
            add_cfg(CFG_TOLERANCE, ($urandom_range(0, 3) == 0) ? $urandom :
                    $urandom_range(0, 32'h00020000) - 32'h00010000);
            load_track(n);
            for (int q = 0; q < 6; q++) add_query(near_coord(), near_coord());
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending.size() != 0 || i_valid || projections_due.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (!failed) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire
